[hdl/arb_pkg.sv]
// Shared types and constants for the audio ring buffer device.
// Used by every module of the block and by the stream interface users.
package arb_pkg;

   localparam logic [2:0] KIND_REG_READ  = 3'd0;
   localparam logic [2:0] KIND_REG_WRITE = 3'd1;
   localparam logic [2:0] KIND_BUF_WRITE = 3'd2;
   localparam logic [2:0] KIND_BUF_READ  = 3'd3;
   localparam logic [2:0] KIND_TICK      = 3'd4;

   localparam logic [2:0] IDX_FREQ     = 3'd0;
   localparam logic [2:0] IDX_CHANNELS = 3'd1;
   localparam logic [2:0] IDX_SAMPLES  = 3'd2;
   localparam logic [2:0] IDX_SIZE     = 3'd3;
   localparam logic [2:0] IDX_INIT     = 3'd4;
   localparam logic [2:0] IDX_COUNT    = 3'd5;

   localparam logic [15:0] REG_SPAN   = 16'd24;
   localparam logic [31:0] START_CODE = 32'd2;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] addr;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [7:0]  sample;
      logic        sample_from_buffer;
      logic        error;
   } rsp_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

   typedef struct packed {
      logic mem_to_read_data;
      logic mem_to_sample;
   } res_sel_type;

endpackage

[hdl/arb_stream_if.sv]
// Valid/ready stream channel carrying one word of a chosen payload type.
// No dependencies; instantiated with arb_pkg::req_type or arb_pkg::rsp_type.
interface arb_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hdl/arb_store.sv]
// Sample store: single-port byte memory with a registered read port.
// Control comes from arb_ctrl as a store_ctl_type; depends on arb_pkg.
module arb_store import arb_pkg::*; #(
   parameter int DEPTH  = 65536,
   parameter int ADDR_W = 16
) (
   input  logic                clock,
   input  store_ctl_type       ctl,
   input  logic [ADDR_W-1:0]   addr,
   input  logic [7:0]          wdata,
   output logic [7:0]          rdata
);

   logic [7:0] store_mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_mem[addr] <= wdata;
      end
      if (ctl.rd_en) begin
         rdata_ff <= store_mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hdl/arb_ctrl.sv]
// Register file, playback pointer/count and word decode for the audio buffer.
// Drives the sample store port and the non-memory result fields; uses arb_pkg.
module arb_ctrl import arb_pkg::*; #(
   parameter int BUF_BYTES = 65536,
   parameter int PTR_W     = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  req_type           item,
   output store_ctl_type     store_ctl,
   output logic [PTR_W-1:0]  mem_addr,
   output logic [7:0]        mem_wdata,
   output rsp_type           rsp_part,
   output res_sel_type       rsp_sel
);

   localparam logic [31:0]      BUF_LIMIT = 32'(BUF_BYTES);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(BUF_BYTES - 1);

   logic [31:0]      freq_ff, freq_in;
   logic [31:0]      channels_ff, channels_in;
   logic [31:0]      samples_ff, samples_in;
   logic [31:0]      init_ff, init_in;
   logic [31:0]      count_ff, count_in;
   logic [PTR_W-1:0] read_pointer_ff, read_pointer_in;
   logic             playing_ff, playing_in;

   logic [31:0]      addr_ext;
   logic             reg_ok;
   logic             buf_hit;
   logic             tick_go;
   logic [2:0]       reg_idx;
   logic [31:0]      reg_rdata;

   assign addr_ext = 32'(item.addr);
   assign reg_ok   = (item.addr[1:0] == 2'b00) && (item.addr < REG_SPAN);
   assign buf_hit  = addr_ext < BUF_LIMIT;
   assign reg_idx  = item.addr[4:2];
   assign tick_go  = playing_ff && (count_ff != 32'd0);

   always_comb begin
      case (reg_idx)
         IDX_FREQ:     reg_rdata = freq_ff;
         IDX_CHANNELS: reg_rdata = channels_ff;
         IDX_SAMPLES:  reg_rdata = samples_ff;
         IDX_SIZE:     reg_rdata = BUF_LIMIT;
         IDX_INIT:     reg_rdata = init_ff;
         default:      reg_rdata = count_ff;
      endcase
   end

   always_comb begin
      freq_in         = freq_ff;
      channels_in     = channels_ff;
      samples_in      = samples_ff;
      init_in         = init_ff;
      count_in        = count_ff;
      read_pointer_in = read_pointer_ff;
      playing_in      = playing_ff;
      store_ctl       = '0;
      rsp_part        = '0;
      rsp_sel         = '0;
      mem_addr        = addr_ext[PTR_W-1:0];
      mem_wdata       = item.write_data[7:0];
      case (item.kind)
         KIND_REG_READ: begin
            if (reg_ok) begin
               rsp_part.read_data = reg_rdata;
            end else begin
               rsp_part.error = 1'b1;
            end
         end
         KIND_REG_WRITE: begin
            if (!reg_ok || reg_idx == IDX_SIZE) begin
               rsp_part.error = 1'b1;
            end else begin
               case (reg_idx)
                  IDX_FREQ:     freq_in     = item.write_data;
                  IDX_CHANNELS: channels_in = item.write_data;
                  IDX_SAMPLES:  samples_in  = item.write_data;
                  IDX_INIT: begin
                     init_in = item.write_data;
                     if (item.write_data == START_CODE) begin
                        playing_in = 1'b1;
                     end
                  end
                  default:      count_in    = item.write_data;
               endcase
            end
         end
         KIND_BUF_WRITE: begin
            store_ctl.wr_en = fire && buf_hit;
         end
         KIND_BUF_READ: begin
            store_ctl.rd_en          = fire && buf_hit;
            rsp_sel.mem_to_read_data = buf_hit;
         end
         KIND_TICK: begin
            mem_addr = read_pointer_ff;
            if (tick_go) begin
               store_ctl.rd_en       = fire;
               rsp_sel.mem_to_sample = 1'b1;
               read_pointer_in       = (read_pointer_ff == PTR_LAST) ? '0
                                       : read_pointer_ff + PTR_W'(1);
               count_in              = count_ff - 32'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff         <= '0;
         channels_ff     <= '0;
         samples_ff      <= '0;
         init_ff         <= '0;
         count_ff        <= '0;
         read_pointer_ff <= '0;
         playing_ff      <= 1'b0;
      end else if (fire) begin
         freq_ff         <= freq_in;
         channels_ff     <= channels_in;
         samples_ff      <= samples_in;
         init_ff         <= init_in;
         count_ff        <= count_in;
         read_pointer_ff <= read_pointer_in;
         playing_ff      <= playing_in;
      end
   end

   ap_ptr_range: assert property (@(posedge clock) disable iff (reset)
      read_pointer_ff <= PTR_LAST)
      else $error("read pointer beyond buffer");

   ap_count_sat: assert property (@(posedge clock) disable iff (reset)
      fire && item.kind == KIND_TICK && count_ff == 32'd0 |=> count_ff == 32'd0)
      else $error("count underflow");

   ap_idle_ptr: assert property (@(posedge clock) disable iff (reset)
      !playing_ff |=> $stable(read_pointer_ff) || $past(reset))
      else $error("pointer moved while not playing");

endmodule

[hdl/audio_ring_buffer_device.sv]
// Audio ring buffer device: one request word in, one response word out.
// Request channel req_chan carries kind/addr/write_data (register read or
// write, buffer byte write or read, play tick). Response channel rsp_chan
// returns read_data, sample, sample_from_buffer and error for every request.
// A request held in the request stage passes through arb_ctrl into the response
// register. Throughput: one request per cycle while rsp_chan does not stall,
// set by the single-port sample store doing one byte access per word.
// The request stage holds one word and the response register another, so a
// new request is taken while a finished response waits; when rsp_chan stalls
// both fill and req_chan.ready drops until the response is taken.
// Reset (synchronous, active high) clears the valid flags, the register file,
// the playback pointer, the count and the playing flag. The sample store is
// not cleared; bytes must be written before they are read or played.
// Depends on arb_pkg, arb_stream_if, arb_ctrl and arb_store.
module audio_ring_buffer_device import arb_pkg::*; #(
   parameter int BUF_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   arb_stream_if.sink   req_chan,
   arb_stream_if.source rsp_chan
);

   localparam int PTR_W = $clog2(BUF_BYTES);

   logic             s1_valid_ff;
   req_type          s1_item_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_part_ff;
   res_sel_type      rsp_sel_ff;

   logic             s2_load;
   logic             fire;
   store_ctl_type    store_ctl;
   logic [PTR_W-1:0] mem_addr;
   logic [7:0]       mem_wdata;
   logic [7:0]       mem_rdata;
   rsp_type          rsp_part_in;
   res_sel_type      rsp_sel_in;
   rsp_type          rsp_word;

   assign s2_load       = !rsp_valid_ff || rsp_chan.ready;
   assign fire          = s1_valid_ff && s2_load;
   assign req_chan.ready = !s1_valid_ff || s2_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         s1_valid_ff <= 1'b1;
      end else if (fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_item_ff <= req_chan.payload;
      end
   end

   arb_ctrl #(
      .BUF_BYTES (BUF_BYTES),
      .PTR_W     (PTR_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (s1_item_ff),
      .store_ctl (store_ctl),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .rsp_part  (rsp_part_in),
      .rsp_sel   (rsp_sel_in)
   );

   arb_store #(
      .DEPTH  (BUF_BYTES),
      .ADDR_W (PTR_W)
   ) u_store (
      .clock (clock),
      .ctl   (store_ctl),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_load) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_part_ff <= rsp_part_in;
         rsp_sel_ff  <= rsp_sel_in;
      end
   end

   always_comb begin
      rsp_word = rsp_part_ff;
      if (rsp_sel_ff.mem_to_read_data) begin
         rsp_word.read_data = 32'(mem_rdata);
      end
      rsp_word.sample             = rsp_sel_ff.mem_to_sample ? mem_rdata : 8'd0;
      rsp_word.sample_from_buffer = rsp_sel_ff.mem_to_sample;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_word;

   ap_no_fire_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !fire)
      else $error("stage advanced into stalled response");

   ap_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> s1_valid_ff && rsp_valid_ff)
      else $error("request side blocked with free space");

   ap_sel_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_sel_ff.mem_to_sample |->
         !rsp_sel_ff.mem_to_read_data && !rsp_part_ff.error)
      else $error("tick response mixed with access response");

endmodule

[tb/sv/arb_response_checker.sv]
// Response checker for audio_ring_buffer_device: predicts each response word
// from accepted request words and compares it with the words the block returns.
// Depends on arb_pkg.
module arb_response_checker import arb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_word,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_word,
   output int      mismatch_count,
   output int      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUF_BYTES = 65536;

   logic [31:0] freq_q;
   logic [31:0] chan_q;
   logic [31:0] samp_q;
   logic [31:0] init_q;
   logic [31:0] left_q;
   logic [15:0] pos_q;
   logic        on_q;
   logic [7:0]  store_mem [BUF_BYTES];
   rsp_type     expected_q [$];

   initial mismatch_count = 0;
   initial pending_count = 0;

   function automatic rsp_type predict_response(req_type w);
      rsp_type    r;
      logic [2:0] idx;
      logic       reg_ok;
      r = '0;
      idx = w.addr[4:2];
      reg_ok = (w.addr[1:0] == 2'b00) && (w.addr < REG_SPAN);
      case (w.kind)
         KIND_REG_READ: begin
            if (!reg_ok) begin
               r.error = 1'b1;
            end else begin
               case (idx)
                  IDX_FREQ:     r.read_data = freq_q;
                  IDX_CHANNELS: r.read_data = chan_q;
                  IDX_SAMPLES:  r.read_data = samp_q;
                  IDX_SIZE:     r.read_data = 32'(BUF_BYTES);
                  IDX_INIT:     r.read_data = init_q;
                  IDX_COUNT:    r.read_data = left_q;
                  default:      r.read_data = '0;
               endcase
            end
         end
         KIND_REG_WRITE: begin
            if (!reg_ok || idx == IDX_SIZE) begin
               r.error = 1'b1;
            end else begin
               case (idx)
                  IDX_FREQ:     freq_q = w.write_data;
                  IDX_CHANNELS: chan_q = w.write_data;
                  IDX_SAMPLES:  samp_q = w.write_data;
                  IDX_INIT: begin
                     init_q = w.write_data;
                     if (w.write_data == START_CODE) on_q = 1'b1;
                  end
                  IDX_COUNT:    left_q = w.write_data;
                  default: ;
               endcase
            end
         end
         KIND_BUF_WRITE: store_mem[w.addr] = w.write_data[7:0];
         KIND_BUF_READ:  r.read_data = {24'd0, store_mem[w.addr]};
         KIND_TICK: begin
            if (on_q && left_q != 0) begin
               r.sample = store_mem[pos_q];
               r.sample_from_buffer = 1'b1;
               pos_q = pos_q + 16'd1;   // 16-bit pointer wraps at the buffer size
               left_q = left_q - 32'd1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         freq_q = '0;
         chan_q = '0;
         samp_q = '0;
         init_q = '0;
         left_q = '0;
         pos_q = '0;
         on_q = 1'b0;
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected response word %h", $realtime, rsp_word);
            end else begin
               want = expected_q.pop_front();
               if (rsp_word.read_data !== want.read_data ||
                   rsp_word.sample !== want.sample ||
                   rsp_word.sample_from_buffer !== want.sample_from_buffer ||
                   rsp_word.error !== want.error) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: mismatch read_data %h/%h sample %h/%h",
                               " from_buf %b/%b error %b/%b"},
                              $realtime, want.read_data, rsp_word.read_data,
                              want.sample, rsp_word.sample,
                              want.sample_from_buffer, rsp_word.sample_from_buffer,
                              want.error, rsp_word.error);
               end
            end
         end
         if (req_valid && req_ready)
            expected_q.push_back(predict_response(req_word));
      end
      pending_count <= expected_q.size();
   end

endmodule

[tb/sv/tb_top.sv]
// Top of the audio_ring_buffer_device testbench: clock, reset, request words
// and response back-pressure, with arb_response_checker judging the responses.
// Depends on arb_pkg, arb_stream_if, arb_response_checker and the block.
module tb_top;
   import arb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 360;
   localparam int QUIET_LIMIT  = 2000;

   logic clock = 1'b0;
   logic reset;
   int   idle_pct = 0;
   int   stall_pct = 0;
   int   quiet_cycles = 0;
   int   mismatch_count;
   int   pending_count;

   // shadow of playback so no unwritten byte is ever read or played
   bit          byte_written [65536];
   logic        play_on = 1'b0;
   logic [31:0] play_left = '0;
   logic [15:0] play_pos = '0;

   arb_stream_if #(.payload_type(req_type)) req_if ();
   arb_stream_if #(.payload_type(rsp_type)) rsp_if ();

   audio_ring_buffer_device dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   arb_response_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_word       (req_if.payload),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_word       (rsp_if.payload),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic push_word(logic [2:0] k, logic [15:0] a, logic [31:0] d);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= req_type'{k, a, d};
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic post_request(logic [2:0] k, logic [15:0] a, logic [31:0] d);
      if (k == KIND_BUF_READ && !byte_written[a]) begin
         push_word(KIND_BUF_WRITE, a, $urandom);
         byte_written[a] = 1'b1;
      end
      if (k == KIND_TICK && play_on && play_left != 0 && !byte_written[play_pos]) begin
         push_word(KIND_BUF_WRITE, play_pos, $urandom);
         byte_written[play_pos] = 1'b1;
      end
      case (k)
         KIND_REG_WRITE: begin
            if (a[1:0] == 2'b00 && a < REG_SPAN) begin
               if (a[4:2] == IDX_INIT && d == START_CODE) play_on = 1'b1;
               if (a[4:2] == IDX_COUNT) play_left = d;
            end
         end
         KIND_BUF_WRITE: byte_written[a] = 1'b1;
         KIND_TICK: begin
            if (play_on && play_left != 0) begin
               play_pos = play_pos + 16'd1;
               play_left = play_left - 32'd1;
            end
         end
         default: ;
      endcase
      push_word(k, a, d);
   endtask

   task automatic random_request();
      int          pick;
      logic [2:0]  k;
      logic [2:0]  idx;
      logic [15:0] a;
      logic [31:0] d;
      pick = $urandom_range(99);
      d = $urandom;
      idx = 3'($urandom_range(5));
      a = {11'd0, idx, 2'b00};
      if (pick < 35) begin
         k = (pick < 15) ? KIND_REG_READ : KIND_REG_WRITE;
         if ($urandom_range(99) < 15) a = 16'($urandom);
         if (idx == IDX_COUNT && $urandom_range(3) != 0) d = $urandom_range(40);
         if (idx == IDX_INIT && $urandom_range(1) == 0) d = START_CODE;
      end else if (pick < 65) begin
         k = (pick < 55) ? KIND_BUF_WRITE : KIND_BUF_READ;
         a = ($urandom_range(1) == 0) ? play_pos + 16'($urandom_range(63)) : 16'($urandom);
      end else if (pick < 95) begin
         k = KIND_TICK;
         a = 16'($urandom);
      end else begin
         k = 3'($urandom_range(7, 5));
         a = 16'($urandom);
      end
      post_request(k, a, d);
   endtask

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      post_request(KIND_TICK, 16'd0, 32'd0);
      for (int i = 0; i < 6; i++) post_request(KIND_REG_READ, 16'(i * 4), 32'd0);
      post_request(KIND_REG_WRITE, 16'd0, 32'hFFFF_FFFF);
      post_request(KIND_REG_WRITE, 16'd4, 32'h1234_5678);
      post_request(KIND_REG_WRITE, 16'd8, 32'h0000_0000);
      post_request(KIND_REG_WRITE, 16'd12, 32'hDEAD_BEEF);
      post_request(KIND_REG_READ, 16'd1, 32'd0);
      post_request(KIND_REG_READ, 16'd24, 32'd0);
      post_request(KIND_REG_WRITE, 16'hFFFF, 32'hFFFF_FFFF);
      post_request(KIND_REG_WRITE, 16'd16, 32'd1);
      post_request(KIND_TICK, 16'hFFFF, 32'hFFFF_FFFF);
      post_request(KIND_BUF_WRITE, 16'd0, 32'hFFFF_FFAB);
      post_request(KIND_BUF_WRITE, 16'hFFFF, 32'h0000_0000);
      post_request(KIND_BUF_READ, 16'hFFFF, 32'd0);
      post_request(KIND_REG_WRITE, 16'd20, 32'd2);
      post_request(KIND_REG_WRITE, 16'd16, START_CODE);
      repeat (3) post_request(KIND_TICK, 16'd0, 32'd0);
      post_request(KIND_REG_READ, 16'd20, 32'd0);
      post_request(KIND_REG_WRITE, 16'd16, START_CODE);
      post_request(KIND_REG_WRITE, 16'd16, 32'd7);
      for (int k = 5; k < 8; k++) post_request(3'(k), 16'hFFFF, 32'hFFFF_FFFF);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 67; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 67; end
            default: begin idle_pct = 28; stall_pct = 28; end
         endcase
         repeat (RANDOM_ITEMS / 4) random_request();
      end
      req_if.valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

[files.f]
hdl/arb_pkg.sv
hdl/arb_stream_if.sv
hdl/arb_store.sv
hdl/arb_ctrl.sv
hdl/audio_ring_buffer_device.sv
tb/sv/arb_response_checker.sv
tb/sv/tb_top.sv
